@@ hw/rtl/text_line_column_segmenter_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the text line and column segmenter
// Implication checks on the rising clock edge, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_LINE_COLUMN_SEGMENTER_ASSERT_SVH
`define TEXT_LINE_COLUMN_SEGMENTER_ASSERT_SVH

// Same-cycle implication.
`define TLCS_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("segmenter assertion failed");

// Next-cycle implication.
`define TLCS_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("segmenter assertion failed");

`endif

@@ hw/rtl/tlcs_pkg.sv @@
// ----------------------------------------------------------------------------
// tlcs_pkg
// Shared types and constants of the text line and column segmenter.
// ----------------------------------------------------------------------------
package tlcs_pkg;

  localparam int MAX_WIDTH_DEF        = 1024;
  localparam int MAX_COLUMN_MARKS_DEF = 32;
  localparam int QUEUE_DEPTH          = 4;   // power of two

  localparam int POS_W       = 11;
  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int LEVEL_W     = 4;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = 2;

  localparam logic [CFG_W-1:0]   FRAME_WIDTH_RESET  = 11'd640;
  localparam logic [CFG_W-1:0]   FRAME_HEIGHT_RESET = 11'd480;
  localparam logic [LEVEL_W-1:0] LIGHT_LEVEL_RESET  = 4'd12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_LIGHT_LEVEL  = 2'd2
  } cfg_idx_e;

  typedef enum logic [OUT_TUSER_W-1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_ROW    = 2'd1,
    KIND_COLUMN = 2'd2
  } kind_e;

  // One queue entry per accepted pixel.
  typedef struct packed {
    logic             text;
    logic             row_mark;
    logic [POS_W-1:0] row_pos;
    logic             frame_end;
    logic [POS_W-1:0] height;
    logic [POS_W-1:0] width;
  } entry_t;

  typedef struct packed {
    logic clearing;
    logic walk_done;
  } back_status_t;

endpackage

@@ hw/rtl/tlcs_queue.sv @@
// ----------------------------------------------------------------------------
// tlcs_queue
// Short FIFO of classified pixels between the front and the back.
// ----------------------------------------------------------------------------
module tlcs_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tlcs_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output tlcs_pkg::entry_t entry_o
);

  localparam int Depth = tlcs_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(Depth);
  localparam int CW    = $clog2(Depth + 1);

  tlcs_pkg::entry_t slot_q [Depth];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointers wrap naturally since the depth is a power of two.
  always_comb begin
    wr_d  = do_push ? wr_q + PW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + PW'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= entry_i;
    end
  end

endmodule

@@ hw/rtl/tlcs_colmem.sv @@
// ----------------------------------------------------------------------------
// tlcs_colmem
// Column text flags: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tlcs_colmem #(
  parameter int MAX_WIDTH = tlcs_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] waddr_i,
  input  logic                         wdata_i,
  input  logic                         re_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] raddr_i,
  output logic                         rdata_o
);

  logic mem_q [MAX_WIDTH];
  logic rdata_q;

  // A read and a write of the same address in one cycle return the old flag.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/tlcs_front.sv @@
// ----------------------------------------------------------------------------
// tlcs_front
// Configuration registers, pixel binarization and row/frame position tracking.
// ----------------------------------------------------------------------------
module tlcs_front #(
  parameter int MAX_WIDTH = tlcs_pkg::MAX_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [tlcs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tlcs_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                 s_tvalid_i,
  output logic                                 s_tready_o,
  input  logic [tlcs_pkg::IN_TDATA_W-1:0]      s_tdata_i,
  input  tlcs_pkg::back_status_t               bk_status_i,
  input  logic                                 q_full_i,
  output logic                                 q_push_o,
  output tlcs_pkg::entry_t                     q_entry_o,
  output logic                                 mem_we_o,
  output logic [$clog2(MAX_WIDTH)-1:0]         mem_addr_o,
  output logic [$clog2(MAX_WIDTH+1)-1:0]       hw_o
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int LW = $clog2(MAX_WIDTH + 1);
  localparam int PW = tlcs_pkg::POS_W;

  logic [tlcs_pkg::CFG_W-1:0]   fw_q, fh_q;
  logic [tlcs_pkg::LEVEL_W-1:0] ll_q;

  logic [XW-1:0] cx_q, cx_d;
  logic [PW-1:0] ry_q, ry_d;
  logic          rht_q, rht_d;
  logic          pb_q, pb_d;
  logic          hold_q, hold_d;
  logic [LW-1:0] hw_q, hw_d;

  logic [12:0]   fw_ext, cx_next;
  logic [PW-1:0] w_eff, h_eff;
  logic          accept, text, row_text, row_end, frame_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= tlcs_pkg::FRAME_WIDTH_RESET;
      fh_q <= tlcs_pkg::FRAME_HEIGHT_RESET;
      ll_q <= tlcs_pkg::LIGHT_LEVEL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tlcs_pkg::CFG_FRAME_WIDTH:  fw_q <= cfg_data_i;
        tlcs_pkg::CFG_FRAME_HEIGHT: fh_q <= cfg_data_i;
        tlcs_pkg::CFG_LIGHT_LEVEL:  ll_q <= cfg_data_i[tlcs_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    fw_ext = 13'(fw_q);
    if (fw_q == '0) begin
      w_eff = PW'(1);
    end else if (fw_ext > 13'(MAX_WIDTH)) begin
      w_eff = PW'(MAX_WIDTH);
    end else begin
      w_eff = fw_q;
    end
    h_eff = (fh_q == '0) ? PW'(1) : fh_q;
  end

  // Background only when all three upper nibbles are above the light level.
  assign text = !((s_tdata_i[7:4] > ll_q) && (s_tdata_i[15:12] > ll_q) &&
                  (s_tdata_i[23:20] > ll_q));

  assign s_tready_o = !hold_q && !bk_status_i.clearing && !q_full_i;
  assign accept     = s_tvalid_i && s_tready_o;
  assign row_text   = rht_q || text;
  assign cx_next    = 13'(cx_q) + 13'd1;
  assign row_end    = (cx_next >= 13'(w_eff));
  assign frame_end  = row_end && ((12'(ry_q) + 12'd1) >= 12'(h_eff));

  always_comb begin
    cx_d   = cx_q;
    ry_d   = ry_q;
    rht_d  = rht_q;
    pb_d   = pb_q;
    hold_d = hold_q;
    hw_d   = hw_q;
    if (bk_status_i.walk_done) begin
      hold_d = 1'b0;
      hw_d   = '0;
    end
    if (accept) begin
      if (text && (cx_next > 13'(hw_q))) begin
        hw_d = LW'(cx_next);
      end
      if (row_end) begin
        cx_d  = '0;
        rht_d = 1'b0;
        if (frame_end) begin
          ry_d   = '0;
          pb_d   = 1'b0;
          hold_d = 1'b1;
        end else begin
          ry_d = ry_q + PW'(1);
          pb_d = !row_text;
        end
      end else begin
        cx_d  = cx_q + XW'(1);
        rht_d = row_text;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q   <= '0;
      ry_q   <= '0;
      rht_q  <= 1'b0;
      pb_q   <= 1'b0;
      hold_q <= 1'b0;
      hw_q   <= '0;
    end else begin
      cx_q   <= cx_d;
      ry_q   <= ry_d;
      rht_q  <= rht_d;
      pb_q   <= pb_d;
      hold_q <= hold_d;
      hw_q   <= hw_d;
    end
  end

  always_comb begin
    q_entry_o.text      = text;
    q_entry_o.row_mark  = row_end && row_text && pb_q;
    q_entry_o.row_pos   = ry_q;
    q_entry_o.frame_end = frame_end;
    q_entry_o.height    = h_eff;
    q_entry_o.width     = w_eff;
  end

  assign q_push_o   = accept;
  assign mem_we_o   = accept && text;
  assign mem_addr_o = cx_q;
  assign hw_o       = hw_q;

endmodule

@@ hw/rtl/tlcs_back.sv @@
// ----------------------------------------------------------------------------
// tlcs_back
// Result sequencer: pixel and row results, frame-end column walk, clearing.
// ----------------------------------------------------------------------------
module tlcs_back #(
  parameter int MAX_WIDTH        = tlcs_pkg::MAX_WIDTH_DEF,
  parameter int MAX_COLUMN_MARKS = tlcs_pkg::MAX_COLUMN_MARKS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               q_valid_i,
  input  tlcs_pkg::entry_t                   q_entry_i,
  output logic                               q_pop_o,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]     hw_i,
  output logic                               mem_re_o,
  output logic [$clog2(MAX_WIDTH)-1:0]       mem_raddr_o,
  output logic                               mem_we_o,
  output logic [$clog2(MAX_WIDTH)-1:0]       mem_waddr_o,
  input  logic                               mem_rdata_i,
  output tlcs_pkg::back_status_t             status_o,
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  output logic [tlcs_pkg::OUT_TDATA_W-1:0]   m_tdata_o,
  output logic [tlcs_pkg::OUT_TUSER_W-1:0]   m_tuser_o,
  output logic                               m_tlast_o
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int LW = $clog2(MAX_WIDTH + 1);
  localparam int MW = $clog2(MAX_COLUMN_MARKS + 1);
  localparam int PW = tlcs_pkg::POS_W;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_ROW    = 7'b0000100,
    ST_HEIGHT = 7'b0001000,
    ST_WALK   = 7'b0010000,
    ST_WIDTH  = 7'b0100000,
    ST_SPARE  = 7'b1000000
  } bk_state_e;

  bk_state_e        state_q, state_d;
  tlcs_pkg::entry_t cur_q, cur_d;
  logic [XW-1:0]    clr_q, clr_d;
  logic [LW-1:0]    ix_q, ix_d, lim_q, lim_d;
  logic [XW-1:0]    x1_q, x1_d;
  logic             pb_q, pb_d;
  logic [MW-1:0]    marks_q, marks_d;
  logic             ovf_q, ovf_d;

  logic              ov_q, ov_d;
  tlcs_pkg::kind_e   okind_q, okind_d;
  logic              otext_q, otext_d;
  logic [PW-1:0]     opos_q, opos_d;
  logic              oovf_q, oovf_d;
  logic              olast_q, olast_d;

  logic              can_emit, emit, mark, room, advance;
  tlcs_pkg::kind_e   e_kind;
  logic              e_text, e_ovf, e_last;
  logic [PW-1:0]     e_pos;
  logic [12:0]       w13, hw13;

  assign can_emit = !ov_q || m_tready_i;
  assign w13      = 13'(cur_q.width);
  assign hw13     = 13'(hw_i);
  assign mark     = mem_rdata_i && pb_q && (13'(x1_q) < w13);
  assign room     = (marks_q < MW'(MAX_COLUMN_MARKS));
  assign advance  = !(mark && room) || can_emit;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    clr_d       = clr_q;
    ix_d        = ix_q;
    lim_d       = lim_q;
    x1_d        = x1_q;
    pb_d        = pb_q;
    marks_d     = marks_q;
    ovf_d       = ovf_q;
    q_pop_o     = 1'b0;
    mem_re_o    = 1'b0;
    mem_we_o    = 1'b0;
    mem_raddr_o = '0;
    mem_waddr_o = '0;
    status_o    = '0;
    emit        = 1'b0;
    e_kind      = tlcs_pkg::KIND_PIXEL;
    e_text      = 1'b0;
    e_pos       = '0;
    e_ovf       = 1'b0;
    e_last      = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        status_o.clearing = 1'b1;
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        clr_d       = clr_q + XW'(1);
        if (clr_q == XW'(MAX_WIDTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i && can_emit) begin
          q_pop_o = 1'b1;
          cur_d   = q_entry_i;
          emit    = 1'b1;
          e_text  = q_entry_i.text;
          e_last  = !(q_entry_i.row_mark || q_entry_i.frame_end);
          if (q_entry_i.row_mark) begin
            state_d = ST_ROW;
          end else if (q_entry_i.frame_end) begin
            state_d = ST_HEIGHT;
          end
        end
      end
      ST_ROW: begin
        if (can_emit) begin
          emit    = 1'b1;
          e_kind  = tlcs_pkg::KIND_ROW;
          e_pos   = cur_q.row_pos;
          e_last  = !cur_q.frame_end;
          state_d = cur_q.frame_end ? ST_HEIGHT : ST_IDLE;
        end
      end
      ST_HEIGHT: begin
        if (can_emit) begin
          emit        = 1'b1;
          e_kind      = tlcs_pkg::KIND_ROW;
          e_pos       = cur_q.height;
          lim_d       = LW'((w13 > hw13) ? w13 : hw13);
          mem_re_o    = 1'b1;
          mem_we_o    = 1'b1;
          ix_d        = LW'(1);
          x1_d        = '0;
          pb_d        = 1'b0;
          marks_d     = '0;
          ovf_d       = 1'b0;
          state_d     = ST_WALK;
        end
      end
      ST_WALK: begin
        // Flag of column x1 is in the read register; each read also clears it.
        if (advance) begin
          pb_d = !mem_rdata_i;
          if (mark) begin
            if (room) begin
              emit    = 1'b1;
              e_kind  = tlcs_pkg::KIND_COLUMN;
              e_pos   = PW'(x1_q);
              marks_d = marks_q + MW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
          if (ix_q < lim_q) begin
            mem_re_o    = 1'b1;
            mem_we_o    = 1'b1;
            mem_raddr_o = ix_q[XW-1:0];
            mem_waddr_o = ix_q[XW-1:0];
            x1_d        = ix_q[XW-1:0];
            ix_d        = ix_q + LW'(1);
          end else begin
            state_d = ST_WIDTH;
          end
        end
      end
      ST_WIDTH: begin
        if (can_emit) begin
          emit               = 1'b1;
          e_kind             = tlcs_pkg::KIND_COLUMN;
          e_pos              = cur_q.width;
          e_ovf              = ovf_q;
          e_last             = 1'b1;
          status_o.walk_done = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ov_d    = ov_q;
    okind_d = okind_q;
    otext_d = otext_q;
    opos_d  = opos_q;
    oovf_d  = oovf_q;
    olast_d = olast_q;
    if (emit) begin
      ov_d    = 1'b1;
      okind_d = e_kind;
      otext_d = e_text;
      opos_d  = e_pos;
      oovf_d  = e_ovf;
      olast_d = e_last;
    end else if (m_tready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    ix_q    <= ix_d;
    lim_q   <= lim_d;
    x1_q    <= x1_d;
    pb_q    <= pb_d;
    marks_q <= marks_d;
    ovf_q   <= ovf_d;
    okind_q <= okind_d;
    otext_q <= otext_d;
    opos_q  <= opos_d;
    oovf_q  <= oovf_d;
    olast_q <= olast_d;
  end

  assign m_tvalid_o = ov_q;
  assign m_tdata_o  = {3'b000, oovf_q, opos_q, otext_q};
  assign m_tuser_o  = okind_q;
  assign m_tlast_o  = olast_q;

endmodule

@@ hw/rtl/text_line_column_segmenter.sv @@
// ----------------------------------------------------------------------------
// text_line_column_segmenter
// Binarizes a raster pixel stream and emits row, height, column and width
// marks of the text layout at row and frame ends.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  s_*       in         one RGB pixel, tdata: red, green, blue
//  m_*       out        one result, tuser: kind; tdata: text, position, overflow
//  cfg_*     in         register write: frame_width, frame_height, light_level
//
// A pixel is accepted every cycle while the queue has room; it yields its pixel
// beat and, ending a text row after a blank row, its row mark beat. At frame
// end the back walks the column flag memory one column per cycle unless a
// column mark is stalled, over max(width, last text column + 1) columns, after
// the height mark; pixel input is held off from the last pixel until the width
// mark is out. After reset the flag memory is cleared over all MAX_WIDTH
// columns; no pixel is taken during that pass, configuration writes are taken
// at any time. A stalled output holds its beat; the front fills the queue.
// ----------------------------------------------------------------------------
`include "text_line_column_segmenter_assert.svh"

module text_line_column_segmenter #(
  parameter int MAX_WIDTH        = tlcs_pkg::MAX_WIDTH_DEF,
  parameter int MAX_COLUMN_MARKS = tlcs_pkg::MAX_COLUMN_MARKS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration writes.
  input  logic                             cfg_we_i,
  input  logic [tlcs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tlcs_pkg::CFG_W-1:0]       cfg_data_i,
  // Pixel input.
  input  logic                             s_tvalid_i,
  output logic                             s_tready_o,
  // [7:0] red, [15:8] green, [23:16] blue
  input  logic [tlcs_pkg::IN_TDATA_W-1:0]  s_tdata_i,
  // Result output.
  output logic                             m_tvalid_o,
  input  logic                             m_tready_i,
  // [0] text_pixel, [11:1] mark_position, [12] marks_overflow, [15:13] zero
  output logic [tlcs_pkg::OUT_TDATA_W-1:0] m_tdata_o,
  // [1:0] result_kind
  output logic [tlcs_pkg::OUT_TUSER_W-1:0] m_tuser_o,
  output logic                             m_tlast_o
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int LW = $clog2(MAX_WIDTH + 1);

  tlcs_pkg::back_status_t bk_status;
  tlcs_pkg::entry_t       push_entry, head_entry;
  logic                   q_push, q_full, q_pop, q_valid;
  logic                   fr_we, bk_we, bk_re, mem_we, mem_wdata, mem_rdata;
  logic [XW-1:0]          fr_addr, bk_waddr, bk_raddr, mem_waddr;
  logic [LW-1:0]          hw;

  tlcs_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .bk_status_i (bk_status),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (push_entry),
    .mem_we_o    (fr_we),
    .mem_addr_o  (fr_addr),
    .hw_o        (hw)
  );

  tlcs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  // The back only writes (zeros) while the front is held off, so it wins.
  assign mem_we    = bk_we || fr_we;
  assign mem_waddr = bk_we ? bk_waddr : fr_addr;
  assign mem_wdata = !bk_we;

  tlcs_colmem #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_colmem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (bk_re),
    .raddr_i (bk_raddr),
    .rdata_o (mem_rdata)
  );

  tlcs_back #(
    .MAX_WIDTH        (MAX_WIDTH),
    .MAX_COLUMN_MARKS (MAX_COLUMN_MARKS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (head_entry),
    .q_pop_o     (q_pop),
    .hw_i        (hw),
    .mem_re_o    (bk_re),
    .mem_raddr_o (bk_raddr),
    .mem_we_o    (bk_we),
    .mem_waddr_o (bk_waddr),
    .mem_rdata_i (mem_rdata),
    .status_o    (bk_status),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o),
    .m_tlast_o   (m_tlast_o)
  );

  // No pixel may enter while the flag memory is being cleared.
  `TLCS_ASSERT_IMPL(a_no_pixel_in_clear, clk_i, rst_ni, s_tvalid_i && s_tready_o, !bk_status.clearing)
  // The last pixel of a frame holds off input until the column walk is done.
  `TLCS_ASSERT_NEXT(a_hold_after_frame, clk_i, rst_ni, s_tvalid_i && s_tready_o && push_entry.frame_end, !s_tready_o)
  // The overflow flag only rides on the width mark, which closes the pixel.
  `TLCS_ASSERT_IMPL(a_ovf_on_width, clk_i, rst_ni, m_tvalid_o && m_tdata_o[12], m_tlast_o && (m_tuser_o == tlcs_pkg::KIND_COLUMN))
  // Pixel results carry no position.
  `TLCS_ASSERT_IMPL(a_pixel_no_pos, clk_i, rst_ni, m_tvalid_o && (m_tuser_o == tlcs_pkg::KIND_PIXEL), m_tdata_o[11:1] == 11'd0)

endmodule

@@ tb/tb_text_line_column_segmenter.sv @@
// ----------------------------------------------------------------------------
// tb_text_line_column_segmenter
// Self-checking bench for the text line and column segmenter. Pixels are
// streamed in frame by frame. An in-bench model binarizes each accepted pixel
// and tracks the row and column layout, and every result beat is compared
// with the beat that the model says is due next.
// ----------------------------------------------------------------------------
module tb_text_line_column_segmenter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD       = 10;
  localparam int QUIET_LIMIT      = 8000;  // cycles without any beat
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES      = 64;
  localparam int REPORT_LIMIT     = 10;

  // One result beat as the bench expects it, split into its fields.
  typedef struct packed {
    tlcs_pkg::kind_e            kind;
    logic                       text;
    logic [tlcs_pkg::POS_W-1:0] pos;
    logic                       ovf;
    logic                       last;
  } seg_beat_t;

  logic                             clk_i      = 1'b0;
  logic                             rst_ni     = 1'b0;
  logic                             cfg_we_i   = 1'b0;
  logic [tlcs_pkg::CFG_IDX_W-1:0]   cfg_idx_i  = tlcs_pkg::CFG_FRAME_WIDTH;
  logic [tlcs_pkg::CFG_W-1:0]       cfg_data_i = '0;
  logic                             s_tvalid_i = 1'b0;
  logic                             s_tready_o;
  // [7:0] red, [15:8] green, [23:16] blue
  logic [tlcs_pkg::IN_TDATA_W-1:0]  s_tdata_i  = '0;
  logic                             m_tvalid_o;
  logic                             m_tready_i = 1'b0;
  // [0] text_pixel, [11:1] mark_position, [12] marks_overflow, [15:13] zero
  logic [tlcs_pkg::OUT_TDATA_W-1:0] m_tdata_o;
  // [1:0] result_kind
  logic [tlcs_pkg::OUT_TUSER_W-1:0] m_tuser_o;
  logic                             m_tlast_o;

  text_line_column_segmenter dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .s_tdata_i (s_tdata_i),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_o (m_tdata_o),
    .m_tuser_o (m_tuser_o),
    .m_tlast_o (m_tlast_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Register copies as the block holds them.
  logic [tlcs_pkg::CFG_W-1:0]   shadow_width  = tlcs_pkg::FRAME_WIDTH_RESET;
  logic [tlcs_pkg::CFG_W-1:0]   shadow_height = tlcs_pkg::FRAME_HEIGHT_RESET;
  logic [tlcs_pkg::LEVEL_W-1:0] shadow_level  = tlcs_pkg::LIGHT_LEVEL_RESET;

  // Layout state of the frame in progress.
  bit          col_text [tlcs_pkg::MAX_WIDTH_DEF];
  bit          row_text       = 1'b0;
  bit          prev_row_blank = 1'b0;
  int unsigned col_x          = 0;
  int unsigned row_y          = 0;

  seg_beat_t                       layout_beats_due[$];  // oldest first
  logic [tlcs_pkg::IN_TDATA_W-1:0] pixel_backlog[$];     // pixels not yet accepted

  int unsigned pixels_queued = 0;
  int unsigned beats_seen    = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  bit          s_beat_taken  = 1'b0;
  bit          long_hold_req = 1'b0;
  bit          long_hold_done = 1'b0;
  int unsigned hold_left     = 0;

  // Zero means one; widths beyond the flag memory are clipped to it.
  function automatic int unsigned active_width();
    if (shadow_width == 0) return 1;
    if (shadow_width > tlcs_pkg::MAX_WIDTH_DEF) return tlcs_pkg::MAX_WIDTH_DEF;
    return shadow_width;
  endfunction

  function automatic int unsigned active_height();
    return (shadow_height == 0) ? 1 : shadow_height;
  endfunction

  function automatic seg_beat_t make_beat(tlcs_pkg::kind_e kind, logic text,
                                          int unsigned pos, logic ovf);
    seg_beat_t b;
    b.kind = kind;
    b.text = text;
    b.pos  = tlcs_pkg::POS_W'(pos);
    b.ovf  = ovf;
    b.last = 1'b0;
    return b;
  endfunction

  // Works out every beat that one accepted pixel causes and updates the layout.
  function automatic void segment_pixel(logic [tlcs_pkg::IN_TDATA_W-1:0] px);
    seg_beat_t   beats[$];
    logic        is_text;
    logic        run_blank;
    logic        dropped;
    int unsigned w;
    int unsigned h;
    int unsigned marks;
    int unsigned x;
    w = active_width();
    h = active_height();
    // Background only when all three upper nibbles sit above the light level.
    is_text = !(px[7:4] > shadow_level && px[15:12] > shadow_level &&
                px[23:20] > shadow_level);
    beats.push_back(make_beat(tlcs_pkg::KIND_PIXEL, is_text, 0, 1'b0));
    if (is_text) begin
      if (col_x < tlcs_pkg::MAX_WIDTH_DEF) col_text[col_x] = 1'b1;
      row_text = 1'b1;
    end
    if (col_x + 1 >= w) begin
      // Row end: a text row right after a blank run opens a new line.
      if (row_text && prev_row_blank)
        beats.push_back(make_beat(tlcs_pkg::KIND_ROW, 1'b0, row_y, 1'b0));
      prev_row_blank = !row_text;
      row_text = 1'b0;
      col_x = 0;
      if (row_y + 1 >= h) begin
        // Frame end: height, column starts up to the cap, then the width.
        beats.push_back(make_beat(tlcs_pkg::KIND_ROW, 1'b0, h, 1'b0));
        marks = 0;
        dropped = 1'b0;
        run_blank = 1'b0;
        for (x = 0; x < w; x++) begin
          if (col_text[x] && run_blank) begin
            if (marks < tlcs_pkg::MAX_COLUMN_MARKS_DEF) begin
              beats.push_back(make_beat(tlcs_pkg::KIND_COLUMN, 1'b0, x, 1'b0));
              marks++;
            end else begin
              dropped = 1'b1;
            end
          end
          run_blank = !col_text[x];
        end
        beats.push_back(make_beat(tlcs_pkg::KIND_COLUMN, 1'b0, w, dropped));
        foreach (col_text[i]) col_text[i] = 1'b0;
        prev_row_blank = 1'b0;
        row_y = 0;
      end else begin
        row_y++;
      end
    end else begin
      col_x++;
    end
    beats[beats.size() - 1].last = 1'b1;
    foreach (beats[i]) layout_beats_due.push_back(beats[i]);
  endfunction

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("ERROR at %0t ns: %s", $time, msg);
  endfunction

  // Builds a pixel that the current light level reads as text or, below level 15, as background.
  function automatic logic [tlcs_pkg::IN_TDATA_W-1:0] make_pixel(bit want_text);
    logic [tlcs_pkg::IN_TDATA_W-1:0] px;
    int unsigned                     c;
    px = tlcs_pkg::IN_TDATA_W'($urandom);
    if (want_text || shadow_level == 4'd15) begin
      c = $urandom_range(2);
      px[c * 8 + 4 +: 4] = 4'($urandom_range(shadow_level, 0));
    end else begin
      for (c = 0; c < 3; c++) px[c * 8 + 4 +: 4] = 4'($urandom_range(15, shadow_level + 1));
    end
    return px;
  endfunction

  function automatic void queue_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pixel_backlog.push_back({b, g, r});
    pixels_queued++;
  endfunction

  // Sizes are mostly small so that frames close quickly; the extremes show up
  // now and then and leave a frame open until a later size change ends it.
  function automatic logic [tlcs_pkg::CFG_W-1:0] pick_size(int unsigned typical_max);
    case ($urandom_range(19))
      0: return '0;
      1: return 11'd1;
      2: return 11'd1024;
      3: return 11'd2047;
      default: return tlcs_pkg::CFG_W'($urandom_range(typical_max, 2));
    endcase
  endfunction

  // All register writes happen at the falling edge and are taken at the next
  // rising edge; the shadow copy is updated when the write is driven.
  task automatic write_reg(tlcs_pkg::cfg_idx_e idx, logic [tlcs_pkg::CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      tlcs_pkg::CFG_FRAME_WIDTH:  shadow_width  = value;
      tlcs_pkg::CFG_FRAME_HEIGHT: shadow_height = value;
      tlcs_pkg::CFG_LIGHT_LEVEL:  shadow_level  = value[tlcs_pkg::LEVEL_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pixel_backlog.size() != 0 || layout_beats_due.size() != 0) @(posedge clk_i);
  endtask

  // Queues the rest of the open frame with a random layout of text blocks, or odd-column
  // stripes. A cut, or a rest over 120 pixels, leaves the frame open for a later size change.
  task automatic queue_frame(bit striped, bit allow_cut);
    bit          col_on [tlcs_pkg::MAX_WIDTH_DEF];
    bit          row_on;
    bit          want_text;
    int unsigned w;
    int unsigned h;
    int unsigned y0;
    int unsigned x;
    int unsigned remaining;
    int unsigned budget;
    int unsigned n;
    w = active_width();
    h = active_height();
    y0 = (row_y < h) ? row_y : h - 1;
    x = (col_x < w) ? col_x : w - 1;
    remaining = (h - 1 - y0) * w + (w - x);
    budget = remaining;
    if (remaining > 120 || (allow_cut && $urandom_range(5) == 0))
      budget = $urandom_range((remaining < 12) ? remaining : 12, 1);
    foreach (col_on[i]) col_on[i] = ($urandom_range(2) != 0);
    row_on = ($urandom_range(2) != 0);
    for (n = 0; n < budget; n++) begin
      if (striped) want_text = x[0];
      else if (row_on && col_on[x]) want_text = ($urandom_range(3) != 0);
      else want_text = ($urandom_range(15) == 0);
      pixel_backlog.push_back(make_pixel(want_text));
      pixels_queued++;
      if (x + 1 >= w) begin
        x = 0;
        row_on = ($urandom_range(2) != 0);
      end else begin
        x++;
      end
    end
  endtask

  // A one-by-one frame ends whatever frame is open with a single pixel.
  task automatic close_frame();
    write_reg(tlcs_pkg::CFG_FRAME_WIDTH, 11'd1);
    write_reg(tlcs_pkg::CFG_FRAME_HEIGHT, 11'd1);
    queue_frame(1'b0, 1'b0);
    wait_drained();
  endtask

  task automatic random_bursts(int unsigned upto);
    int unsigned n;
    while (pixels_queued < upto) begin
      if ($urandom_range(1) != 0) begin
        if ($urandom_range(2) != 0) write_reg(tlcs_pkg::CFG_FRAME_WIDTH, pick_size(16));
        if ($urandom_range(2) != 0) write_reg(tlcs_pkg::CFG_FRAME_HEIGHT, pick_size(6));
        if ($urandom_range(1) != 0)
          write_reg(tlcs_pkg::CFG_LIGHT_LEVEL, tlcs_pkg::CFG_W'($urandom_range(15)));
      end
      if ($urandom_range(7) == 0) begin
        // Raw noise: any byte in any channel.
        for (n = $urandom_range(8, 1); n != 0; n--) begin
          pixel_backlog.push_back(tlcs_pkg::IN_TDATA_W'($urandom));
          pixels_queued++;
        end
      end else begin
        queue_frame(1'b0, 1'b1);
      end
      wait_drained();
    end
  endtask

  // Rising edge: predict from the accepted pixel first, then check the result
  // beat against the oldest beat still due.
  always @(posedge clk_i) begin
    bit        in_fire;
    bit        out_fire;
    seg_beat_t want;
    in_fire  = (rst_ni && s_tvalid_i && s_tready_o) === 1'b1;
    out_fire = (rst_ni && m_tvalid_o && m_tready_i) === 1'b1;
    s_beat_taken <= in_fire;
    quiet_cycles <= (in_fire || out_fire) ? 0 : quiet_cycles + 1;
    if (in_fire) begin
      segment_pixel(s_tdata_i);
      void'(pixel_backlog.pop_front());
    end
    if (out_fire) begin
      beats_seen++;
      if (layout_beats_due.size() == 0) begin
        note_mismatch($sformatf("beat %0d arrived with nothing due: tuser=%0d tdata=%h last=%0b",
                                beats_seen, m_tuser_o, m_tdata_o, m_tlast_o));
      end else begin
        want = layout_beats_due.pop_front();
        if (m_tuser_o !== want.kind || m_tdata_o[0] !== want.text ||
            m_tdata_o[11:1] !== want.pos || m_tdata_o[12] !== want.ovf ||
            m_tlast_o !== want.last)
          note_mismatch($sformatf({"beat %0d: expected kind=%0d text=%0b pos=%0d ovf=%0b ",
                                   "last=%0b, got kind=%0d text=%0b pos=%0d ovf=%0b last=%0b"},
                                  beats_seen, want.kind, want.text, want.pos, want.ovf,
                                  want.last, m_tuser_o, m_tdata_o[0], m_tdata_o[11:1],
                                  m_tdata_o[12], m_tlast_o));
      end
    end
  end

  // Pixel source: a beat on offer stays unchanged until it is taken.
  always @(negedge clk_i) begin
    if (!s_tvalid_i || s_beat_taken) begin
      if (pixel_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        s_tvalid_i <= 1'b1;
        s_tdata_i  <= pixel_backlog[0];
      end else begin
        s_tvalid_i <= 1'b0;
      end
    end
  end

  // Result sink: random back-pressure, plus one long hold on request so that
  // the block's queue fills and it stops taking pixels.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      m_tready_i <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      hold_left      <= LONG_HOLD_CYCLES;
      long_hold_done <= 1'b1;
      m_tready_i     <= 1'b0;
    end else begin
      m_tready_i <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Timeout: no beat moved for %0d cycles, %0d beats still due",
             QUIET_LIMIT, layout_beats_due.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Sender idles a little, receiver a lot.
    src_idle_pct  = 22;
    sink_idle_pct = 61;

    // A 4x3 frame: text in row 0 column 0 (no marks there), a blank row, then
    // text again so that row 2 and column 2 open new runs. Channel nibbles
    // equal to the level count as dark, one above it as light.
    write_reg(tlcs_pkg::CFG_FRAME_WIDTH, 11'd4);
    write_reg(tlcs_pkg::CFG_FRAME_HEIGHT, 11'd3);
    write_reg(tlcs_pkg::CFG_LIGHT_LEVEL, 11'd12);
    queue_rgb(8'h00, 8'h00, 8'h00);
    queue_rgb(8'hFF, 8'hFF, 8'hFF);
    queue_rgb(8'hD0, 8'hD0, 8'hD0);
    queue_rgb(8'hDF, 8'hEF, 8'hFF);
    queue_rgb(8'hF0, 8'hD5, 8'hE9);
    queue_rgb(8'hFF, 8'hFF, 8'hFF);
    queue_rgb(8'hD1, 8'hD2, 8'hD3);
    queue_rgb(8'hE0, 8'hE0, 8'hE0);
    queue_rgb(8'hCF, 8'hFF, 8'hFF);
    queue_rgb(8'hFF, 8'hFF, 8'hFF);
    queue_rgb(8'hFF, 8'hCF, 8'hFF);
    queue_rgb(8'hFF, 8'hFF, 8'hC0);
    wait_drained();

    // One-pixel frames at level zero: only a zero nibble makes text.
    write_reg(tlcs_pkg::CFG_FRAME_WIDTH, 11'd1);
    write_reg(tlcs_pkg::CFG_FRAME_HEIGHT, 11'd1);
    write_reg(tlcs_pkg::CFG_LIGHT_LEVEL, 11'd0);
    queue_rgb(8'h10, 8'h10, 8'h10);
    queue_rgb(8'h0F, 8'hFF, 8'hFF);
    queue_rgb(8'hFF, 8'h0A, 8'hFF);
    wait_drained();

    // Zero sizes act as one; at level 15 even white is text.
    write_reg(tlcs_pkg::CFG_FRAME_WIDTH, 11'd0);
    write_reg(tlcs_pkg::CFG_FRAME_HEIGHT, 11'd0);
    write_reg(tlcs_pkg::CFG_LIGHT_LEVEL, 11'd15);
    queue_rgb(8'hFF, 8'hFF, 8'hFF);
    wait_drained();

    // Oversized width and a 1024-row frame, cut short by a size change:
    // column 4 already lies past the new width, so the next pixel ends row 0.
    write_reg(tlcs_pkg::CFG_FRAME_WIDTH, 11'd2047);
    write_reg(tlcs_pkg::CFG_FRAME_HEIGHT, 11'd1024);
    write_reg(tlcs_pkg::CFG_LIGHT_LEVEL, 11'd12);
    queue_rgb(8'hFF, 8'hFF, 8'hFF);
    queue_rgb(8'h00, 8'hFF, 8'hFF);
    queue_rgb(8'hFF, 8'hFF, 8'hFF);
    queue_rgb(8'h20, 8'h30, 8'h40);
    queue_rgb(8'hEE, 8'hEE, 8'hEE);
    wait_drained();
    write_reg(tlcs_pkg::CFG_FRAME_WIDTH, 11'd3);
    write_reg(tlcs_pkg::CFG_FRAME_HEIGHT, 11'd2);
    queue_frame(1'b0, 1'b0);
    wait_drained();

    random_bursts(60);

    // Roles swapped: the sender idles a lot, the receiver a little.
    src_idle_pct  = 61;
    sink_idle_pct = 22;

    // Odd-column stripes over 66 columns give 33 column starts, one more
    // than the block keeps, so the width mark must flag the overflow.
    close_frame();
    write_reg(tlcs_pkg::CFG_FRAME_WIDTH, 11'd66);
    write_reg(tlcs_pkg::CFG_LIGHT_LEVEL, 11'd9);
    queue_frame(1'b1, 1'b0);
    wait_drained();

    random_bursts(150);

    // No idling. A full 16x4 frame is offered while the receiver holds off.
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    close_frame();
    write_reg(tlcs_pkg::CFG_FRAME_WIDTH, 11'd16);
    write_reg(tlcs_pkg::CFG_FRAME_HEIGHT, 11'd4);
    queue_frame(1'b0, 1'b0);
    long_hold_req = 1'b1;
    wait_drained();

    random_bursts(215);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && layout_beats_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/tlcs_pkg.sv
hw/rtl/tlcs_queue.sv
hw/rtl/tlcs_colmem.sv
hw/rtl/tlcs_front.sv
hw/rtl/tlcs_back.sv
hw/rtl/text_line_column_segmenter.sv
tb/tb_text_line_column_segmenter.sv
